// ----- hw/rtl/mips_tlb_address_translator_assert.svh -----
// Assertion macros for the TLB translator
`ifndef MIPS_TLB_ADDRESS_TRANSLATOR_ASSERT_SVH
`define MIPS_TLB_ADDRESS_TRANSLATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MTLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MTLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/mtlb_pkg.sv -----
`default_nettype none
package mtlb_pkg;
    localparam logic [1:0] MODE_XLATE = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] KIND_DWRITE = 2'd2;
    localparam logic [1:0] KIND_DREAD  = 2'd1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REFILL   = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_MODIFIED = 3'd3;
    localparam logic [2:0] ST_ADDR_ERR = 3'd4;
    localparam logic [2:0] ST_TABLE    = 3'd5;

    localparam logic [0:0] CFG_ASID = 1'd0;
    localparam logic [0:0] CFG_ERL  = 1'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_index;
        logic [31:0] virtual_address;
        logic [1:0]  access_kind;
        logic [2:0]  size_log2;
        logic        aligned_access;
        logic [31:0] lo_even_word;
        logic [31:0] lo_odd_word;
        logic [31:0] hi_word;
        logic [24:0] mask_word;
    } t_req;

    typedef struct packed {
        logic [31:0] physical_address;
        logic [2:0]  status;
        logic [31:0] read_lo_even;
        logic [31:0] read_lo_odd;
        logic [31:0] read_hi;
        logic [24:0] read_mask;
    } t_rsp;

    // one table entry as stored
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
        logic [24:0] mask;
        logic        glob;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE, S_SCAN, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic clear;    // reset scan pointer
        logic step;     // examine next entry
        logic finish;   // drive result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;
        logic scan_end;
    } t_sts;
endpackage
`default_nettype wire

// ----- hw/rtl/mtlb_ctrl.sv -----
`default_nettype none
module mtlb_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  mtlb_pkg::t_sts   i_sts,
    output mtlb_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import mtlb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!i_sts.needs_scan || i_sts.scan_end) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                o_cmd.clear = i_start;
            end
            S_SCAN: begin
                o_cmd.step = i_sts.needs_scan;
            end
            S_DONE: o_cmd.finish = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/mtlb_dpath.sv -----
`default_nettype none
module mtlb_dpath #(
    parameter int ENTRIES = 48
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  mtlb_pkg::t_cmd   i_cmd,
    input  mtlb_pkg::t_req   i_req,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [7:0]        i_cfg_data,
    output mtlb_pkg::t_sts   o_sts,
    output mtlb_pkg::t_rsp   o_rsp,
    output logic             o_strobe
);
    import mtlb_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // entry table: one write and one registered read a cycle; entries not
    // written since reset read as zero through the valid bits
    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    t_entry             r_rd;
    logic               r_rd_vld;
    logic [IW-1:0]      r_raddr, n_raddr;

    logic [7:0]  r_asid;
    logic        r_erl;
    t_req        r_req;
    logic        r_found;
    logic [31:0] r_pa;
    logic [2:0]  r_st;
    logic        r_scan;
    t_rsp        r_rsp, n_rsp;
    logic        r_strobe;

    logic          idx_ok;
    logic          req_idx_ok;
    logic [IW-1:0] idx;
    logic          wr_en;
    t_entry        wr_ent;
    t_entry        ent;
    logic [31:0]   va;
    logic [31:0]   xl_pa;
    logic [2:0]    xl_st;
    logic          xl_scan;
    logic          hit;
    logic [31:0]   e_pa;
    logic [2:0]    e_st;

    assign va         = r_req.virtual_address;
    assign idx_ok     = {2'b0, i_req.entry_index} < 8'(ENTRIES);
    assign req_idx_ok = {2'b0, r_req.entry_index} < 8'(ENTRIES);
    assign idx        = i_req.entry_index[IW-1:0];
    assign wr_en      = i_rst_n && i_cmd.load && (i_req.mode == MODE_WRITE) && idx_ok;
    assign ent        = r_rd_vld ? r_rd : '0;

    always_comb begin
        wr_ent.lo   = {i_req.lo_odd_word[31:1], 1'b0, i_req.lo_even_word[31:1], 1'b0};
        wr_ent.hi   = i_req.hi_word & ~{7'd0, i_req.mask_word};
        wr_ent.mask = i_req.mask_word;
        wr_ent.glob = i_req.lo_even_word[0] & i_req.lo_odd_word[0];
    end

    // segment decision at acceptance
    always_comb begin
        logic [31:0] szm;
        logic        misalign;
        szm = (32'd1 << i_req.size_log2) - 32'd1;
        misalign = (i_req.access_kind == KIND_DREAD) && i_req.aligned_access &&
                   (i_req.size_log2 >= 3'd1) && (i_req.size_log2 <= 3'd3) &&
                   ((i_req.virtual_address & szm) != 32'd0);
        xl_pa   = 32'd0;
        xl_st   = ST_TABLE;
        xl_scan = 1'b0;
        if (i_req.mode == MODE_XLATE) begin
            if (misalign) begin
                xl_st = ST_ADDR_ERR;
            end else if (!i_req.virtual_address[31] && r_erl) begin
                xl_pa = i_req.virtual_address;
                xl_st = ST_OK;
            end else if (i_req.virtual_address[31:30] == 2'b10) begin
                xl_pa = i_req.virtual_address & 32'h1FFF_FFFF;
                xl_st = ST_OK;
            end else begin
                xl_st   = ST_REFILL;
                xl_scan = 1'b1;
            end
        end
    end

    // one entry compare per scan cycle, on the entry held in r_rd
    always_comb begin
        logic [31:0] m, vmask, omask, lo;
        m     = {7'd0, ent.mask};
        vmask = ~m & ~32'h1FFF;
        omask = (m >> 1) | 32'hFFF;
        hit   = ((va & vmask) == (ent.hi & vmask)) &&
                (ent.glob || (ent.hi[7:0] == r_asid));
        lo    = ((va & (omask + 32'd1)) != 32'd0) ? ent.lo[63:32] : ent.lo[31:0];
        e_pa  = 32'd0;
        if (!lo[1]) begin
            e_st = ST_INVALID;
        end else if (r_req.access_kind == KIND_DWRITE && !lo[2]) begin
            e_st = ST_MODIFIED;
        end else begin
            e_st = ST_OK;
            e_pa = (va & omask) | ({lo[25:6], 12'd0} & ~omask);
        end
    end

    // read address: held between steps so r_rd stays on the same entry
    always_comb begin
        n_raddr = r_raddr;
        if (i_cmd.clear) begin
            n_raddr = (i_req.mode == MODE_READ && idx_ok) ? idx : '0;
        end else if (i_cmd.step && !hit && (r_raddr != LAST)) begin
            n_raddr = r_raddr + 1'b1;
        end
    end

    assign o_sts.needs_scan = r_scan && !r_found;
    assign o_sts.scan_end   = hit || (r_raddr == LAST);

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[idx] <= wr_ent;
        r_rd     <= r_mem[n_raddr];
        r_rd_vld <= r_vld[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asid   <= '0;
            r_erl    <= 1'b1;
            r_strobe <= 1'b0;
            r_vld    <= '0;
            r_raddr  <= '0;
        end else begin
            r_strobe <= i_cmd.finish;
            r_raddr  <= n_raddr;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ASID) r_asid <= i_cfg_data;
                else r_erl <= i_cfg_data[0];
            end
            if (wr_en) r_vld[idx] <= 1'b1;
        end
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.physical_address = r_pa;
        n_rsp.status           = r_st;
        if (r_req.mode == MODE_READ && req_idx_ok) begin
            n_rsp.read_lo_even = {ent.lo[31:1], ent.glob};
            n_rsp.read_lo_odd  = {ent.lo[63:33], ent.glob};
            n_rsp.read_hi      = ent.hi & ~{7'd0, ent.mask} & ~32'h1F00;
            n_rsp.read_mask    = ent.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_found <= 1'b0;
            r_scan  <= xl_scan;
            r_pa    <= xl_pa;
            r_st    <= xl_st;
        end else if (i_cmd.step && hit) begin
            r_found <= 1'b1;
            r_pa    <= e_pa;
            r_st    <= e_st;
        end
        if (i_cmd.finish) r_rsp <= n_rsp;
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;
endmodule
`default_nettype wire

// ----- hw/rtl/mips_tlb_address_translator.sv -----
// A request is captured on the accepting edge, then passes through the scan state and
// the done state, which registers the result. Table writes, reads and unmapped
// translations leave the scan state at once; a mapped translation compares entries
// there until a hit or the last entry. One entry is compared per cycle.
// Throughput: one item at a time; busy drops in the strobe cycle.
// Reset marks every entry empty (reads as zero), ASID to 0 and error level to 1.
`default_nettype none
module mips_tlb_address_translator #(
    parameter int ENTRIES = 48
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  mtlb_pkg::t_req   i_req,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [7:0]        i_cfg_data,
    output logic             o_strobe,
    output mtlb_pkg::t_rsp   o_rsp
);
    import mtlb_pkg::*;
    `include "mips_tlb_address_translator_assert.svh"

    t_cmd cmd;
    t_sts sts;

    mtlb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    mtlb_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_req),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_sts(sts), .o_rsp(o_rsp), .o_strobe(o_strobe)
    );

    `MTLB_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, cmd.load, !busy, "load while busy")
    `MTLB_ASSERT_NXT(a_strobe_after_finish, i_clk, i_rst_n, cmd.finish, o_strobe, "no strobe")
    `MTLB_ASSERT_IMP(a_strobe_busy_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")
endmodule
`default_nettype wire
